### src/hft_pkg.sv
// Shared types and constants for the hashed fault trigger.
`default_nettype none
package hft_pkg;

	localparam logic [63:0] MIX_GAMMA  = 64'h9E37_79B9_7F4A_7C15;
	localparam int unsigned MIX_SH1    = 30;
	localparam logic [63:0] MIX_M1     = 64'hBF58_476D_1CE4_E5B9;
	localparam int unsigned MIX_SH2    = 27;
	localparam logic [63:0] MIX_M2     = 64'h94D0_49BB_1331_11EB;
	localparam int unsigned MIX_SH3    = 31;
	localparam logic [63:0] STEP_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam logic [63:0] SEED_RESET   = 64'd0;
	localparam logic [63:0] PERIOD_RESET = 64'd1;

	typedef enum logic [0:0] {
		CMD_ADVANCE = 1'b0,
		CMD_PROBE   = 1'b1
	} command_t;

	typedef enum logic [0:0] {
		REG_SEED   = 1'b0,
		REG_PERIOD = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic        command;
		logic [63:0] probe_step;
	} item_t;

	typedef struct packed {
		logic        fire;
		logic        period_error;
		logic [63:0] step_now;
	} result_t;

	typedef struct packed {
		cfg_reg_t    index;
		logic [63:0] data;
	} cfg_write_t;

endpackage
`default_nettype wire

### src/hft_chan_if.sv
// Valid/ready channel carrying one payload beat.
`default_nettype none
interface hft_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### src/hashed_fault_trigger_unit.sv
// Hashed fault trigger: splitmix64 hash of seed plus step, fires when hash mod period is zero.
`default_nettype none
// One item is taken at a time. An item with a nonzero period passes these steps from
// acceptance until the block is ready again: a pre-mix step, two 64-bit products,
// each from three partial products on one shared 32x32 multiplier with a fold step
// after each, a radix-2 restoring remainder unit, and a final step to hand the
// result to the output register. With a zero period the item goes straight to the
// final step, which hands the error result to the output register. A previous
// result that is still not taken holds the block in that final step. The output
// register lets the next item be accepted while the previous result still waits to
// be taken. Configuration writes are taken every cycle.
module hashed_fault_trigger_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	hft_chan_if.sink   item,
	hft_chan_if.source result,
	hft_chan_if.sink   cfg
);
	import hft_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_MUL,
		ST_POST,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t      state_q;
	logic [63:0] seed_q;
	logic [63:0] period_q;
	logic [63:0] step_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] div_q;
	logic [63:0] rem_q;
	logic [1:0]  beat_q;
	logic [5:0]  cnt_q;
	logic        round_q;
	logic        err_q;
	logic        out_valid_q;
	result_t     out_q;

	logic        item_acc;
	logic        cfg_acc;
	logic [63:0] step_next;
	logic [63:0] tested;
	logic [63:0] premix;
	logic [63:0] mul_const;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [64:0] trial;
	logic [64:0] diff;

	assign item.ready   = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.payload = out_q;

	assign item_acc = item.valid && item.ready;
	assign cfg_acc  = cfg.valid && cfg.ready;

	assign step_next = (step_q == STEP_MAX) ? 64'd1 : step_q + 64'd1;
	assign tested    = (item.payload.command == CMD_PROBE) ? item.payload.probe_step
		: step_next;
	assign premix    = (x_q + MIX_GAMMA) ^ ((x_q + MIX_GAMMA) >> MIX_SH1);

	assign mul_const = round_q ? MIX_M2 : MIX_M1;
	assign mul_a     = (beat_q == 2'd2) ? x_q[63:32] : x_q[31:0];
	assign mul_b     = (beat_q == 2'd1) ? mul_const[63:32] : mul_const[31:0];
	assign prod      = 64'(mul_a) * 64'(mul_b);

	assign trial = {rem_q, div_q[63]};
	assign diff  = trial - {1'b0, period_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= SEED_RESET;
			period_q    <= PERIOD_RESET;
			step_q      <= '0;
			x_q         <= '0;
			acc_q       <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			beat_q      <= '0;
			cnt_q       <= '0;
			round_q     <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg.payload.index)
					REG_SEED:   seed_q   <= cfg.payload.data;
					REG_PERIOD: period_q <= cfg.payload.data;
					default: ;
				endcase
			end
			if ((state_q == ST_DONE) && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						if (period_q == 64'd0) begin
							err_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							err_q <= 1'b0;
							if (item.payload.command == CMD_ADVANCE) begin
								step_q <= step_next;
							end
							x_q     <= seed_q + tested;
							state_q <= ST_PRE;
						end
					end
				end
				ST_PRE: begin
					x_q     <= premix;
					round_q <= 1'b0;
					beat_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (beat_q == 2'd0) begin
						acc_q <= prod;
					end else begin
						acc_q[63:32] <= acc_q[63:32] + prod[31:0];
					end
					if (beat_q == 2'd2) begin
						state_q <= ST_POST;
					end
					beat_q <= beat_q + 2'd1;
				end
				ST_POST: begin
					if (!round_q) begin
						x_q     <= acc_q ^ (acc_q >> MIX_SH2);
						round_q <= 1'b1;
						beat_q  <= '0;
						state_q <= ST_MUL;
					end else begin
						div_q   <= acc_q ^ (acc_q >> MIX_SH3);
						rem_q   <= '0;
						cnt_q   <= '1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= diff[64] ? trial[63:0] : diff[63:0];
					div_q <= {div_q[62:0], 1'b0};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || result.ready) begin
						out_q.fire         <= !err_q && (rem_q == 64'd0);
						out_q.period_error <= err_q;
						out_q.step_now     <= step_q;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_advance_bumps: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && (item.payload.command == CMD_ADVANCE) && (period_q != 64'd0)
		|=> step_q != $past(step_q))
		else $error("advance did not change the step counter");

	a_step_held_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> $stable(step_q))
		else $error("step counter moved while an item was in progress");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the completion state");

	a_error_no_fire: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.payload.period_error |-> !result.payload.fire)
		else $error("fire set together with period error");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (cnt_q != 6'd0) |=> (state_q == ST_DIV))
		else $error("remainder unit left before its last step");

endmodule
`default_nettype wire
